>>> sv/csffc_pkg.sv
// Shared types, character codes and status codes of the character-stream calculator.
package csffc_pkg;

    // Word width of the arithmetic datapath and of the operand registers.
    localparam int WORD_WIDTH = 32;
    localparam int CNT_WIDTH  = $clog2(WORD_WIDTH);

    // Bit layout of the result beat.
    localparam int VALUE_WIDTH  = 32;
    localparam int STATUS_WIDTH = 2;
    localparam int OUT_BITS     = VALUE_WIDTH + STATUS_WIDTH;
    localparam int OUT_BYTES    = (OUT_BITS + 7) / 8;
    localparam int OUT_TDATA_W  = OUT_BYTES * 8;

    // Character codes.
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_TIMES   = 8'h2A;
    localparam logic [7:0] CH_DIVIDE  = 8'h2F;

    // Result status codes.
    localparam logic [STATUS_WIDTH-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_BAD_OP   = 2'd2;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        t_alu_op op;
        logic    b_neg;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic div_zero;
    } t_alu_rsp;

endpackage

>>> sv/csffc_alu.sv
// Shared add/subtract unit with a small sequencer for +, -, shift-add * and restoring /.
module csffc_alu
    import csffc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_alu_req              i_req,
    input  logic [WORD_WIDTH-1:0] i_a,
    input  logic [WORD_WIDTH-1:0] i_b,
    output t_alu_rsp              o_rsp,
    output logic [WORD_WIDTH-1:0] o_result
);

    typedef enum logic [2:0] {
        A_IDLE,
        A_NEGB,
        A_ADDSUB,
        A_ABSA,
        A_ABSB,
        A_ITER,
        A_FIX
    } t_alu_state;

    localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(WORD_WIDTH - 1);

    t_alu_state            r_state;
    t_alu_op               r_op;
    logic                  r_b_neg;
    logic                  r_q_neg;
    logic [WORD_WIDTH-1:0] r_a;
    logic [WORD_WIDTH-1:0] r_b;
    logic [WORD_WIDTH-1:0] r_acc;
    logic [WORD_WIDTH-1:0] r_q;
    logic [CNT_WIDTH-1:0]  r_cnt;
    logic [WORD_WIDTH-1:0] r_result;
    logic                  r_done;
    logic                  r_div_zero;

    logic [WORD_WIDTH-1:0] add_x;
    logic [WORD_WIDTH-1:0] add_y;
    logic                  add_sub;
    logic [WORD_WIDTH:0]   add_sum;
    logic [WORD_WIDTH-1:0] rem_sh;

    // Partial remainder shifted left by one, taking the next dividend bit.
    assign rem_sh = {r_acc[WORD_WIDTH-2:0], r_q[WORD_WIDTH-1]};

    // The one adder; with subtraction the carry out means x >= y.
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (r_state)
            A_NEGB: begin
                add_y   = r_b;
                add_sub = r_b_neg;
            end
            A_ADDSUB: begin
                add_x   = r_a;
                add_y   = r_b;
                add_sub = (r_op == ALU_SUB);
            end
            A_ABSA: begin
                add_y   = r_a;
                add_sub = r_a[WORD_WIDTH-1];
            end
            A_ABSB: begin
                add_y   = r_b;
                add_sub = r_b[WORD_WIDTH-1];
            end
            A_ITER: begin
                if (r_op == ALU_DIV) begin
                    add_x   = rem_sh;
                    add_y   = r_b;
                    add_sub = 1'b1;
                end else begin
                    add_x = r_acc;
                    add_y = r_q[0] ? r_a : '0;
                end
            end
            A_FIX: begin
                add_y   = r_q;
                add_sub = r_q_neg;
            end
            default: begin
                add_x   = '0;
            end
        endcase
        add_sum = {1'b0, add_x} + {1'b0, add_y ^ {WORD_WIDTH{add_sub}}}
                  + (WORD_WIDTH + 1)'(add_sub);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= A_IDLE;
            r_done     <= 1'b0;
            r_div_zero <= 1'b0;
            r_cnt      <= '0;
        end else begin
            unique case (r_state)
                A_IDLE: begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_op    <= i_req.op;
                        r_b_neg <= i_req.b_neg;
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_state <= A_NEGB;
                    end
                end
                A_NEGB: begin
                    // Apply the sign of the second operand.
                    r_done <= 1'b0;
                    r_b    <= add_sum[WORD_WIDTH-1:0];
                    r_q    <= add_sum[WORD_WIDTH-1:0];
                    r_acc  <= '0;
                    r_cnt  <= '0;
                    unique case (r_op)
                        ALU_ADD, ALU_SUB: r_state <= A_ADDSUB;
                        ALU_MUL:          r_state <= A_ITER;
                        default:          r_state <= A_ABSA;
                    endcase
                end
                A_ADDSUB: begin
                    r_result   <= add_sum[WORD_WIDTH-1:0];
                    r_div_zero <= 1'b0;
                    r_done     <= 1'b1;
                    r_state    <= A_IDLE;
                end
                A_ABSA: begin
                    r_q     <= add_sum[WORD_WIDTH-1:0];
                    r_q_neg <= r_a[WORD_WIDTH-1] ^ r_b[WORD_WIDTH-1];
                    if (r_b == '0) begin
                        r_result   <= '0;
                        r_div_zero <= 1'b1;
                        r_done     <= 1'b1;
                        r_state    <= A_IDLE;
                    end else begin
                        r_done  <= 1'b0;
                        r_state <= A_ABSB;
                    end
                end
                A_ABSB: begin
                    r_done  <= 1'b0;
                    r_b     <= add_sum[WORD_WIDTH-1:0];
                    r_acc   <= '0;
                    r_cnt   <= '0;
                    r_state <= A_ITER;
                end
                A_ITER: begin
                    r_cnt <= r_cnt + CNT_WIDTH'(1);
                    if (r_op == ALU_DIV) begin
                        r_done <= 1'b0;
                        r_acc  <= add_sum[WORD_WIDTH] ? add_sum[WORD_WIDTH-1:0] : rem_sh;
                        r_q    <= {r_q[WORD_WIDTH-2:0], add_sum[WORD_WIDTH]};
                        if (r_cnt == CNT_LAST) begin
                            r_state <= A_FIX;
                        end
                    end else begin
                        r_done <= (r_cnt == CNT_LAST);
                        r_acc  <= add_sum[WORD_WIDTH-1:0];
                        r_a    <= {r_a[WORD_WIDTH-2:0], 1'b0};
                        r_q    <= {1'b0, r_q[WORD_WIDTH-1:1]};
                        if (r_cnt == CNT_LAST) begin
                            r_result   <= add_sum[WORD_WIDTH-1:0];
                            r_div_zero <= 1'b0;
                            r_state    <= A_IDLE;
                        end
                    end
                end
                A_FIX: begin
                    r_result   <= add_sum[WORD_WIDTH-1:0];
                    r_div_zero <= 1'b0;
                    r_done     <= 1'b1;
                    r_state    <= A_IDLE;
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.div_zero = r_div_zero;
    assign o_result       = r_result;

endmodule

>>> sv/char_stream_four_function_calculator.sv
// Top level of the character-stream four-function calculator.
//
// The block reads one ASCII character per input beat from lines such as "1234-34=". Digits
// build the first operand, the first non-digit is taken as the operator, an optional '+' or
// '-' right after it signs the second operand, and '=' sends one result beat carrying the
// 32-bit wrapped value of +, -, * or truncating / together with a status code (0 ok,
// 1 division by zero, 2 unknown operator; the value is zero when the status is not ok).
// Characters after '=' are ignored until a newline, which starts a new line; a newline
// before '=' gives no result. Every character other than a computing '=' is taken without
// stalling the input. All arithmetic runs on one shared add/subtract unit under a small
// sequencer: on '=' the input stays not ready while the unit works (+ and - add or subtract,
// * takes one shift-add step per cycle, / one restoring quotient bit per cycle plus sign
// handling, where a zero divisor ends it before the quotient steps), and then while the
// result moves into the output register. An unknown operator skips the unit. The output
// register lets further characters in while a result waits to be taken; the next result is
// held back until that beat has gone.
module char_stream_four_function_calculator
    import csffc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream, one character per beat.
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [7:0]             i_s_tdata,   // [7:0] char_code
    // Result stream.
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // [31:0] value, [33:32] status, rest zero
);

    typedef enum logic [1:0] {
        P_FIRST,
        P_AFTER_OP,
        P_SECOND,
        P_DONE
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_HOLD
    } t_state;

    t_state                  r_state;
    t_phase                  r_phase;
    logic [WORD_WIDTH-1:0]   r_first;
    logic [WORD_WIDTH-1:0]   r_second;
    logic [7:0]              r_op;
    logic                    r_second_neg;
    logic                    r_second_begun;
    logic                    r_alu_start;
    t_alu_req                r_alu_req;
    logic [VALUE_WIDTH-1:0]  r_pend_value;
    logic [STATUS_WIDTH-1:0] r_pend_status;
    logic                    r_out_valid;
    logic [VALUE_WIDTH-1:0]  r_out_value;
    logic [STATUS_WIDTH-1:0] r_out_status;

    t_alu_rsp                alu_rsp;
    logic [WORD_WIDTH-1:0]   alu_result;

    logic                    accept;
    logic [7:0]              c;
    logic                    is_digit;
    logic                    is_emit;
    logic [7:0]              op_now;
    logic                    op_known;
    t_alu_op                 op_code;
    logic [WORD_WIDTH-1:0]   first_acc;
    logic [WORD_WIDTH-1:0]   second_acc;
    logic                    out_free;
    logic                    alu_go;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign c          = i_s_tdata;
    assign is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
    assign out_free   = !r_out_valid || i_m_tready;

    // Digit accumulation as acc * 8 + acc * 2 + digit, wrapping at the word width.
    assign first_acc  = (r_first << 3) + (r_first << 1) + WORD_WIDTH'(c[3:0]);
    assign second_acc = (r_second << 3) + (r_second << 1) + WORD_WIDTH'(c[3:0]);

    // An '=' computes in every phase but the one after a result. When it ends the first
    // operand, the '=' itself becomes the operator, which is never a known one.
    assign is_emit = (c == CH_EQUALS) && (r_phase != P_DONE);
    assign op_now  = (r_phase == P_FIRST) ? c : r_op;

    // A computing '=' with a known operator starts the arithmetic unit.
    assign alu_go = accept && (c != CH_NEWLINE) && is_emit && op_known;

    always_comb begin
        op_known = 1'b1;
        op_code  = ALU_ADD;
        case (op_now)
            CH_PLUS:   op_code = ALU_ADD;
            CH_MINUS:  op_code = ALU_SUB;
            CH_TIMES:  op_code = ALU_MUL;
            CH_DIVIDE: op_code = ALU_DIV;
            default:   op_known = 1'b0;
        endcase
    end

    csffc_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_alu_start),
        .i_req    (r_alu_req),
        .i_a      (r_first),
        .i_b      (r_second),
        .o_rsp    (alu_rsp),
        .o_result (alu_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_phase        <= P_FIRST;
            r_first        <= '0;
            r_second       <= '0;
            r_op           <= '0;
            r_second_neg   <= 1'b0;
            r_second_begun <= 1'b0;
            r_alu_start    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_alu_start <= alu_go;
            // While a result is pending, the hold state below decides the output register.
            if (r_out_valid && i_m_tready && (r_state != S_HOLD)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (c == CH_NEWLINE) begin
                            // A newline drops whatever the line held.
                            r_phase        <= P_FIRST;
                            r_first        <= '0;
                            r_second       <= '0;
                            r_op           <= '0;
                            r_second_neg   <= 1'b0;
                            r_second_begun <= 1'b0;
                        end else if (is_emit) begin
                            r_phase <= P_DONE;
                            if (r_phase == P_FIRST) begin
                                r_op <= c;
                            end
                            if (op_known) begin
                                r_alu_req.op    <= op_code;
                                r_alu_req.b_neg <= r_second_neg;
                                r_state         <= S_CALC;
                            end else begin
                                r_pend_value  <= '0;
                                r_pend_status <= ST_BAD_OP;
                                r_state       <= S_HOLD;
                            end
                        end else begin
                            unique case (r_phase)
                                P_FIRST: begin
                                    if (is_digit) begin
                                        r_first <= first_acc;
                                    end else begin
                                        r_op    <= c;
                                        r_phase <= P_AFTER_OP;
                                    end
                                end
                                P_AFTER_OP: begin
                                    // Only the first character after the operator may open the second operand.
                                    if (!r_second_begun) begin
                                        r_second_begun <= 1'b1;
                                        if (is_digit) begin
                                            r_second <= second_acc;
                                            r_phase  <= P_SECOND;
                                        end else if (c == CH_PLUS || c == CH_MINUS) begin
                                            r_second_neg <= (c == CH_MINUS);
                                            r_phase      <= P_SECOND;
                                        end
                                    end
                                end
                                P_SECOND: begin
                                    if (is_digit) begin
                                        r_second <= second_acc;
                                    end else begin
                                        r_phase <= P_AFTER_OP;
                                    end
                                end
                                default: begin
                                    r_phase <= P_DONE;
                                end
                            endcase
                        end
                    end
                end
                S_CALC: begin
                    if (alu_rsp.done) begin
                        if (alu_rsp.div_zero) begin
                            r_pend_value  <= '0;
                            r_pend_status <= ST_DIV_ZERO;
                        end else begin
                            // Sign-extend or truncate the word to the 32-bit result field.
                            r_pend_value  <= VALUE_WIDTH'($signed(alu_result));
                            r_pend_status <= ST_OK;
                        end
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= r_pend_value;
                        r_out_status <= r_pend_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, r_out_status, r_out_value};

    // The arithmetic unit only finishes work that the controller is waiting for.
    a_alu_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> (r_state == S_CALC))
        else $error("arithmetic unit finished outside of a calculation");

    // After a result, further characters of the line start no calculation.
    a_done_phase_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (r_phase == P_DONE)) |=> (r_state == S_IDLE))
        else $error("character after a result started a calculation");

    // An error status always carries a zero value.
    a_error_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (r_out_status != ST_OK)) |-> (r_out_value == '0))
        else $error("error result with a nonzero value");

    // A newline clears the line state.
    a_newline_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (c == CH_NEWLINE)) |=>
            ((r_phase == P_FIRST) && (r_first == '0) && (r_second == '0)
             && !r_second_begun && !r_second_neg))
        else $error("newline did not clear the line state");

    // A pending result waits while the output register is still occupied.
    a_hold_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_HOLD) && r_out_valid && !i_m_tready) |=>
            ((r_state == S_HOLD) && $stable(r_out_value) && $stable(r_out_status)))
        else $error("result overwrote a beat still waiting");

endmodule
